// ----- src/rcsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared types and constants of the reference-counted slot allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcsa_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int REF_BITS_DEF = 8;

  localparam int CFG_W   = 7;
  localparam int OP_W    = 1;
  localparam int IREF_W  = 8;
  localparam int SLOT_W  = 6;
  localparam int STAT_W  = 2;

  localparam logic [CFG_W-1:0] ACTIVE_RST = CFG_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_FREE     = 2'd1,
    ST_ZERO_REFS   = 2'd2,
    ST_BAD_RELEASE = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- src/rcsa_req_if.sv -----
// ----------------------------------------------------------------------------
// rcsa_req_if
// Request channel: valid/ready handshake with the allocate/release payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rcsa_req_if import rcsa_pkg::*; ();
  logic              valid;
  logic              ready;
  opcode_t           opcode;
  logic [IREF_W-1:0] initial_refs;
  logic [SLOT_W-1:0] slot_to_release;

  modport source (output valid, output opcode, output initial_refs,
                  output slot_to_release, input ready);
  modport sink   (input valid, input opcode, input initial_refs,
                  input slot_to_release, output ready);
endinterface

`default_nettype wire

// ----- src/rcsa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rcsa_rsp_if
// Result channel: valid/ready handshake with the grant/free/status payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rcsa_rsp_if import rcsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] granted_slot;
  logic              slot_freed;
  status_t           status;

  modport source (output valid, output granted_slot, output slot_freed,
                  output status, input ready);
  modport sink   (input valid, input granted_slot, input slot_freed,
                  input status, output ready);
endinterface

`default_nettype wire

// ----- src/rcsa_ram.sv -----
// ----------------------------------------------------------------------------
// rcsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/refcounted_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// refcounted_slot_allocator
// Path: count RAM read into stage 1, then grant/release logic into the result
// register. Throughput: 1 request per cycle while the result channel is not
// stalled, set by the single count RAM read port with write forwarding.
// Reset: every slot free, all counts treated as zero, active_slots = 64.
// No clearing pass; the free map doubles as the count valid map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module refcounted_slot_allocator import rcsa_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int REF_BITS = REF_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  rcsa_req_if.sink              in_req,
  rcsa_rsp_if.source            out_rsp,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int IW  = $clog2(SLOTS);
  localparam int EW  = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int RBE = (REF_BITS > IREF_W) ? REF_BITS : IREF_W;

  // config and slot state
  logic [CFG_W-1:0]    cfg_active_r;
  logic [SLOTS-1:0]    free_r, free_nxt;

  // stage 1: request waiting on count RAM data
  logic                s1_vld_r;
  opcode_t             s1_op_r;
  logic [REF_BITS-1:0] s1_refs_r;
  logic [SLOT_W-1:0]   s1_rel_r;

  // write forwarding for back-to-back requests
  logic                fwd_vld_r;
  logic [IW-1:0]       fwd_addr_r;
  logic [REF_BITS-1:0] fwd_data_r;

  // result register
  logic                out_vld_r;
  logic [SLOT_W-1:0]   out_granted_r, out_granted_nxt;
  logic                out_freed_r, out_freed_nxt;
  status_t             out_status_r, out_status_nxt;

  logic                in_acc, s1_adv;
  logic [EW-1:0]       in_rel_ext, s1_rel_ext, grant_ext;
  logic [RBE-1:0]      in_refs_ext;
  logic [IW-1:0]       rd_addr, rel_idx;
  logic [REF_BITS-1:0] rd_data, cur_refs, dec_refs;
  int                  limit;
  logic                found, rel_ok;
  logic [IW-1:0]       found_idx;
  logic                wr_en, clr_en, set_en;
  logic [IW-1:0]       wr_addr;
  logic [REF_BITS-1:0] wr_data;

  assign s1_adv       = s1_vld_r && (!out_vld_r || out_rsp.ready);
  assign in_req.ready = !s1_vld_r || s1_adv;
  assign in_acc       = in_req.valid && in_req.ready;

  assign in_rel_ext  = EW'(in_req.slot_to_release);
  assign rd_addr     = in_rel_ext[IW-1:0];
  assign in_refs_ext = RBE'(in_req.initial_refs);
  assign s1_rel_ext  = EW'(s1_rel_r);
  assign rel_idx     = s1_rel_ext[IW-1:0];

  rcsa_ram #(
    .WIDTH (REF_BITS),
    .DEPTH (SLOTS)
  ) u_refs_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    limit = (int'(cfg_active_r) > SLOTS) ? SLOTS : int'(cfg_active_r);

    // lowest free active slot
    found     = 1'b0;
    found_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_r[i] && (i < limit)) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end

    rel_ok = int'(s1_rel_r) < limit;
    if (free_r[rel_idx]) begin
      cur_refs = '0;
    end else if (fwd_vld_r && (fwd_addr_r == rel_idx)) begin
      cur_refs = fwd_data_r;
    end else begin
      cur_refs = rd_data;
    end
    dec_refs = cur_refs - REF_BITS'(1);

    wr_en           = 1'b0;
    clr_en          = 1'b0;
    set_en          = 1'b0;
    wr_addr         = rel_idx;
    wr_data         = dec_refs;
    out_granted_nxt = '0;
    out_freed_nxt   = 1'b0;
    out_status_nxt  = ST_OK;
    grant_ext       = EW'(found_idx);

    if (s1_op_r == OP_ALLOC) begin
      if (!found) begin
        out_status_nxt = ST_NO_FREE;
      end else if (s1_refs_r == '0) begin
        out_status_nxt = ST_ZERO_REFS;
      end else begin
        wr_en           = s1_adv;
        clr_en          = s1_adv;
        wr_addr         = found_idx;
        wr_data         = s1_refs_r;
        out_granted_nxt = grant_ext[SLOT_W-1:0];
      end
    end else begin
      if (!rel_ok || cur_refs == '0) begin
        out_status_nxt = ST_BAD_RELEASE;
      end else begin
        wr_en = s1_adv;
        if (dec_refs == '0) begin
          set_en        = s1_adv;
          out_freed_nxt = 1'b1;
        end
      end
    end

    free_nxt = free_r;
    if (clr_en) begin
      free_nxt[wr_addr] = 1'b0;
    end
    if (set_en) begin
      free_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r <= ACTIVE_RST;
      free_r       <= '1;
      s1_vld_r     <= 1'b0;
      fwd_vld_r    <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_active_r <= cfg_wdata;
      end
      free_r <= free_nxt;
      if (in_acc) begin
        s1_vld_r  <= 1'b1;
        fwd_vld_r <= wr_en;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_req.opcode;
      s1_refs_r  <= in_refs_ext[REF_BITS-1:0];
      s1_rel_r   <= in_req.slot_to_release;
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
    if (s1_adv) begin
      out_granted_r <= out_granted_nxt;
      out_freed_r   <= out_freed_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.granted_slot = out_granted_r;
  assign out_rsp.slot_freed   = out_freed_r;
  assign out_rsp.status       = out_status_r;

endmodule

`default_nettype wire
